/* src/glc_pkg.sv */
`timescale 1ns / 1ps

package glc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SLOT_W  = 4;

   typedef struct packed {
      logic [15:0] glyph_code;
      logic [7:0]  font_id;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // running result of the tag scan, passed cell to cell
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] best_rank;
      logic [IDX_W-1:0] best_idx;
      logic [IDX_W-1:0] vic_rank;
      logic [IDX_W-1:0] vic_idx;
   } scan_type;

   // broadcast recency / retag update
   typedef struct packed {
      logic             en;
      logic             hit;
      logic [IDX_W-1:0] sel_idx;
      logic [IDX_W-1:0] sel_rank;
   } upd_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] rank;
   } cell_stat_type;

   // entry index masked or zero extended to the slot field
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [SLOT_W+IDX_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

/* src/glyph_lru_cache_lookup.sv */
`timescale 1ns / 1ps
// channel   ports                              direction
// req       req_valid req_ready req_data       in   glyph_code, font_id
// rsp       rsp_valid rsp_ready rsp_data       out  hit, slot
//
// during a lookup the request is held while the scan
// result ripples through the row of ENTRIES registered cells, then the
// update state moves the selected entry to the front and loads the response
// reset (synchronous, active high) invalidates every entry and sets rank i
// on entry i; no clearing pass is needed
// a pending response does not block the next request; the update cycle waits
// only while the previous response beat is still untaken
`default_nettype none

module glyph_lru_cache_lookup
   import glc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   req_type          req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;
   logic             req_beat;
   logic             upd_fire;
   upd_type          upd;
   scan_type         scan_res;

   // scan chain: link 0 is the seed, link ENTRIES the final result
   scan_type         chain [ENTRIES+1];
   cell_stat_type    stat  [ENTRIES];
   logic [ENTRIES-1:0] rank_zero;

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign scan_res  = chain[ENTRIES];

   // update fires once the output register is free
   assign upd_fire = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      upd.en       = upd_fire;
      upd.hit      = scan_res.found;
      upd.sel_idx  = scan_res.found ? scan_res.best_idx  : scan_res.vic_idx;
      upd.sel_rank = scan_res.found ? scan_res.best_rank : scan_res.vic_rank;
   end

   // seed: nothing found, victim search starts at rank zero
   assign chain[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      glc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .req      (req_ff),
         .scan_in  (chain[i]),
         .upd      (upd),
         .scan_out (chain[i+1]),
         .stat     (stat[i])
      );
      assign rank_zero[i] = (stat[i].rank == '0);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_beat) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            // every link has settled by the time the last scan step hands over to update
            if (cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (upd_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = upd_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request held for the whole scan and update
   always_ff @(posedge clock) begin
      if (req_beat) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_ff.hit  <= scan_res.found;
         rsp_ff.slot <= slot_of(upd.sel_idx);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // exactly one entry is most recent
   a_one_front: assert property (@(posedge clock) disable iff (reset)
      $onehot(rank_zero))
      else $error("recency ranks lost the single front entry");

   // a miss evicts the least recent entry
   a_victim_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) && !scan_res.found |-> scan_res.vic_rank == IDX_W'(ENTRIES - 1))
      else $error("victim is not the least recent entry");

   // a hit points at a valid entry
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) && scan_res.found |-> stat[scan_res.best_idx].valid)
      else $error("hit on an invalid entry");

   // an accepted request starts the scan
   a_beat_scan: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == S_SCAN)
      else $error("request beat did not start a scan");

   // a new response comes only from an update
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("response raised outside the update cycle");

endmodule

`default_nettype wire

/* src/glc_cell.sv */
`timescale 1ns / 1ps

module glc_cell
   import glc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    cell_idx,
   input  req_type             req,
   input  scan_type            scan_in,
   input  upd_type             upd,
   output scan_type            scan_out,
   output cell_stat_type       stat
);

   logic [15:0]      tag_code_ff;
   logic [7:0]       tag_font_ff;
   logic             valid_ff;
   logic [IDX_W-1:0] rank_ff;
   scan_type         scan_ff, scan_in_next;
   logic             match;
   logic             is_sel;

   assign match  = valid_ff && (tag_code_ff == req.glyph_code) && (tag_font_ff == req.font_id);
   assign is_sel = (upd.sel_idx == cell_idx);

   always_comb begin
      scan_in_next = scan_in;
      if (match && (!scan_in.found || (rank_ff < scan_in.best_rank))) begin
         scan_in_next.found     = 1'b1;
         scan_in_next.best_rank = rank_ff;
         scan_in_next.best_idx  = cell_idx;
      end
      if (rank_ff > scan_in.vic_rank) begin
         scan_in_next.vic_rank = rank_ff;
         scan_in_next.vic_idx  = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= cell_idx;
      end else if (upd.en) begin
         if (is_sel) begin
            rank_ff <= '0;
            if (!upd.hit) begin
               valid_ff <= 1'b1;
            end
         end else if (rank_ff < upd.sel_rank) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end
   end

   // retag on a miss
   always_ff @(posedge clock) begin
      if (upd.en && is_sel && !upd.hit) begin
         tag_code_ff <= req.glyph_code;
         tag_font_ff <= req.font_id;
      end
   end

   assign scan_out   = scan_ff;
   assign stat.valid = valid_ff;
   assign stat.rank  = rank_ff;

endmodule

/* verif/glc_lookup_checker.sv */
`timescale 1ns / 1ps

module glc_lookup_checker
   import glc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   // shadow of the tag store
   logic [15:0]      line_code [ENTRIES];
   logic [7:0]       line_font [ENTRIES];
   logic             line_live [ENTRIES];
   logic [IDX_W-1:0] line_age  [ENTRIES];

   rsp_type          due_lookups [$];
   rsp_type          want;
   int               errs = 0;

   // one lookup: hit search, victim pick on a miss, move to front
   function automatic rsp_type lru_lookup(input req_type q);
      logic [31:0]      i;
      logic [31:0]      pick;
      logic             found;
      logic [IDX_W-1:0] old_age;
      rsp_type          r;
      pick  = 0;
      found = 1'b0;
      for (i = 0; i < ENTRIES; i++) begin
         if (line_live[i] && line_code[i] == q.glyph_code && line_font[i] == q.font_id
             && (!found || line_age[i] < line_age[pick])) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         // oldest entry goes, unused ones hold the highest ages
         pick = 0;
         for (i = 1; i < ENTRIES; i++) begin
            if (line_age[i] > line_age[pick])
               pick = i;
         end
         line_code[pick] = q.glyph_code;
         line_font[pick] = q.font_id;
         line_live[pick] = 1'b1;
      end
      old_age = line_age[pick];
      for (i = 0; i < ENTRIES; i++) begin
         if (line_age[i] < old_age)
            line_age[i] = line_age[i] + 1'b1;
      end
      line_age[pick] = '0;
      r.hit  = found;
      r.slot = pick[SLOT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            line_code[i] = '0;
            line_font[i] = '0;
            line_live[i] = 1'b0;
            line_age[i]  = i[IDX_W-1:0];
         end
         due_lookups.delete();
      end else begin
         if (req_valid && req_ready)
            due_lookups.push_back(lru_lookup(req_data));
         if (rsp_valid && rsp_ready) begin
            if (due_lookups.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("rsp beat with no lookup pending: hit=%0b slot=%0d",
                           rsp_data.hit, rsp_data.slot);
            end else begin
               want = due_lookups.pop_front();
               if (want.hit !== rsp_data.hit || want.slot !== rsp_data.slot) begin
                  errs++;
                  if (errs <= 10)
                     $display("lookup mismatch: want hit=%0b slot=%0d, got hit=%0b slot=%0d",
                              want.hit, want.slot, rsp_data.hit, rsp_data.slot);
               end
            end
         end
      end
      mismatches  <= errs;
      outstanding <= due_lookups.size();
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import glc_pkg::*;

   // one lookup is a full scan of the row plus the update cycle
   localparam int LOOKUP_CYCLES = ENTRIES + 2;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int      mismatches;
   int      outstanding;
   int      cycles = 0;

   bit      calm;       // no idling on either side
   bit      hold_rsp;   // asks for one long hold-off on the rsp side

   // working set of glyphs that the random lookups mostly draw from
   req_type work_set [24];
   int      set_size;

   glyph_lru_cache_lookup DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   glc_lookup_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [15:0] code, input logic [7:0] font);
      req_type r;
      r.glyph_code = code;
      r.font_id    = font;
      return r;
   endfunction

   // one req beat, preceded by a random gap unless calm
   task automatic send_beat(input req_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender pause until every lookup has answered
   task automatic wait_drained();
      req_valid <= 1'b0;
      // the checker posts its count through a register
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // new working set; some neighbors share a code or a font so that the
   // compare has to look at both tag fields
   task automatic refill_set(input int n);
      set_size = n;
      for (int i = 0; i < n; i++) begin
         work_set[i] = make_req(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
         if (i > 0 && $urandom_range(0, 3) == 0)
            work_set[i].glyph_code = work_set[i-1].glyph_code;
         else if (i > 0 && $urandom_range(0, 3) == 0)
            work_set[i].font_id = work_set[i-1].font_id;
      end
   endtask

   function automatic req_type pick_request();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r = work_set[$urandom_range(0, set_size - 1)];
      if (roll >= 95)
         r = make_req(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      else if (roll >= 85)
         r[$urandom_range(0, 23)] ^= 1'b1;   // near miss: one tag bit off
      return r;
   endfunction

   task automatic run_random(input int n, input int ws);
      refill_set(ws);
      repeat (n) send_beat(pick_request());
   endtask

   // rsp side: random stall per beat, one long hold-off on request
   initial begin : receiver
      int stall;
      bit held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held = 1'b1;
         end
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      calm      = 1'b0;
      hold_rsp  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // code 0 in font 0 must miss on the cleared store, first fill takes the top entry
      send_beat(make_req(16'h0000, 8'h00));
      send_beat(make_req(16'h0000, 8'h00));
      // extremes, and pairs that match on only one tag field
      send_beat(make_req(16'hFFFF, 8'hFF));
      send_beat(make_req(16'hFFFF, 8'h00));
      send_beat(make_req(16'h0000, 8'hFF));
      send_beat(make_req(16'hFFFF, 8'hFF));
      // fill the rest of the store
      for (int k = 1; k <= 12; k++)
         send_beat(make_req(16'(k * 16'h1111), 8'(8'h80 | k)));
      // store full: each new pair evicts the oldest entry
      send_beat(make_req(16'h1234, 8'h56));
      send_beat(make_req(16'h0000, 8'h00));
      send_beat(make_req(16'hFFFF, 8'h00));
      send_beat(make_req(16'h8000, 8'h80));

      // sender pause until the directed beats have all come back
      wait_drained();

      // working set fits: mostly hits
      run_random(500, 12);
      // working set too big: steady evictions
      run_random(400, 20);

      // rsp side holds off while req keeps offering, so the block backs up
      calm     = 1'b1;
      hold_rsp = 1'b1;
      run_random(40, 18);

      // back to back on both sides, working set right at the store size
      run_random(300, 16);
      calm = 1'b0;
      wait_drained();

      run_random(600, 24);

      wait_drained();
      repeat (LOOKUP_CYCLES + 4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
